@@ hdl/pbs_pkg.sv @@
`default_nettype none
package pbs_pkg;

  // Field widths
  localparam int unsigned TempW    = 12;
  localparam int unsigned LimitW   = 11;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned BrightW  = 2;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAlwaysOff = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPressOff  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTempLimit = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPowerOff  = 2'd3;

  // Configuration reset values
  localparam logic [TicksW-1:0] PressOffReset  = 16'd2000;
  localparam logic [LimitW-1:0] TempLimitReset = 11'd680;
  localparam logic [TicksW-1:0] PowerOffReset  = 16'd10000;

  // Brightness codes
  localparam logic [BrightW-1:0] BrightOff   = 2'd0;
  localparam logic [BrightW-1:0] BrightHalf  = 2'd1;
  localparam logic [BrightW-1:0] BrightThree = 2'd2;
  localparam logic [BrightW-1:0] BrightFull  = 2'd3;

  localparam logic [TicksW-1:0] TicksMax = {TicksW{1'b1}};

  // Phase codes seen on the output
  localparam logic [PhaseW-1:0] PhaseBooted   = 3'd0;
  localparam logic [PhaseW-1:0] PhaseDelay    = 3'd1;
  localparam logic [PhaseW-1:0] PhaseHeld     = 3'd2;
  localparam logic [PhaseW-1:0] PhaseOn       = 3'd3;
  localparam logic [PhaseW-1:0] PhaseShutdown = 3'd4;

  typedef enum logic [4:0] {
    StBooted   = 5'b00001,
    StDelay    = 5'b00010,
    StHeld     = 5'b00100,
    StOn       = 5'b01000,
    StShutdown = 5'b10000
  } phase_e;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic              always_off_mode;
    logic [TicksW-1:0] press_off_ticks;
    logic [LimitW-1:0] temp_limit_deci_c;
    logic [TicksW-1:0] power_off_ticks;
  } cfg_t;

  // One registered tick
  typedef struct packed {
    logic             button_pin;
    logic [TempW-1:0] fet_temp_deci_c;
    logic             system_ready;
  } tick_t;

  // One result
  typedef struct packed {
    logic               power_hold;
    logic [BrightW-1:0] brightness_level;
    logic               motor_lock_pulse;
    logic               motor_release_pulse;
    logic               bus_shutdown_pulse;
    logic [PhaseW-1:0]  phase;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_code(input phase_e ph);
    logic [PhaseW-1:0] code;
    unique case (ph)
      StBooted:   code = PhaseBooted;
      StDelay:    code = PhaseDelay;
      StHeld:     code = PhaseHeld;
      StOn:       code = PhaseOn;
      StShutdown: code = PhaseShutdown;
      default:    code = PhaseBooted;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

@@ hdl/power_button_sequencer_top.sv @@
// Channel   | Direction | Contents
// s_axis    | in        | one 1 ms tick: button pin, FET temperature, system ready
// m_axis    | out       | one result word per tick
// cfg       | in        | register index and write data, always ready
//
// Each tick waits in the input register until the result register is free or is
// being taken, and the sequencer then writes its result register; one tick per
// cycle is sustained while the output does not stall. The single next-state step
// between input and result register sets that rate. Reset is asynchronous and
// active low and brings back the booted phase and the default configuration. A
// stalled output holds the result register; the input register still takes a
// word while it is empty.
`default_nettype none
module power_button_sequencer_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] button_pin, [12:1] fet_temp_deci_c, [13] system_ready, [15:14] zero
  input  wire  [pbs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // [0] power_hold, [2:1] brightness_level, [3] motor_lock_pulse,
  // [4] motor_release_pulse, [5] bus_shutdown_pulse, [8:6] phase, [15:9] zero
  output logic [pbs_pkg::OutDataW-1:0]  m_axis_tdata,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [pbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [pbs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pbs_pkg::*;

  cfg_t    cfg;
  tick_t   tick_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    step;
  result_t result;

  assign cfg_ready_o = 1'b1;

  pbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The sequencer steps when a tick waits and the result slot is free.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q.button_pin      <= s_axis_tdata[0];
      tick_q.fet_temp_deci_c <= s_axis_tdata[TempW:1];
      tick_q.system_ready    <= s_axis_tdata[TempW+1];
    end
  end

  pbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .tick_i   (tick_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result.phase, result.bus_shutdown_pulse,
                          result.motor_release_pulse, result.motor_lock_pulse,
                          result.brightness_level, result.power_hold};

endmodule
`default_nettype wire

@@ hdl/pbs_cfg.sv @@
`default_nettype none
module pbs_cfg (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_valid_i,
  input  wire  [pbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [pbs_pkg::CfgDataW-1:0]  cfg_data_i,
  output pbs_pkg::cfg_t                 cfg_o
);
  import pbs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAlwaysOff: cfg_d.always_off_mode   = cfg_data_i[0];
        CfgPressOff:  cfg_d.press_off_ticks   = cfg_data_i[TicksW-1:0];
        CfgTempLimit: cfg_d.temp_limit_deci_c = cfg_data_i[LimitW-1:0];
        CfgPowerOff:  cfg_d.power_off_ticks   = cfg_data_i[TicksW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.always_off_mode   <= 1'b0;
      cfg_q.press_off_ticks   <= PressOffReset;
      cfg_q.temp_limit_deci_c <= TempLimitReset;
      cfg_q.power_off_ticks   <= PowerOffReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hdl/pbs_seq.sv @@
`default_nettype none
module pbs_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  pbs_pkg::tick_t      tick_i,
  input  pbs_pkg::cfg_t       cfg_i,
  output pbs_pkg::result_t    result_o
);
  import pbs_pkg::*;

  phase_e             phase_q, phase_d;
  logic [TicksW-1:0]  press_q, press_d;
  logic [TicksW-1:0]  timer_q, timer_d;
  logic               waiting_q, waiting_d;
  logic [BrightW-1:0] bright_q, bright_d;
  logic               hold_q, hold_d;
  result_t            res_q, res_d;

  logic               pressed;
  logic [TicksW-1:0]  off_limit;
  logic [TicksW-1:0]  press_inc;
  logic [TicksW-1:0]  timer_inc;
  logic               lock, release_p, bus;

  // The button counts only below the temperature limit.
  assign pressed = tick_i.button_pin &&
                   ($signed(tick_i.fet_temp_deci_c) < $signed({1'b0, cfg_i.temp_limit_deci_c}));

  // A zero power-off time behaves as one tick.
  assign off_limit = (cfg_i.power_off_ticks == '0) ? TicksW'(1) : cfg_i.power_off_ticks;
  assign press_inc = (press_q == TicksMax) ? press_q : press_q + TicksW'(1);
  assign timer_inc = timer_q + TicksW'(1);

  // Next-state logic for one tick.
  always_comb begin
    phase_d   = phase_q;
    press_d   = press_q;
    timer_d   = timer_q;
    waiting_d = waiting_q;
    bright_d  = bright_q;
    hold_d    = hold_q;
    lock      = 1'b0;
    release_p = 1'b0;
    bus       = 1'b0;
    unique case (phase_q)
      StDelay: begin
        if (tick_i.system_ready) begin
          lock      = 1'b1;
          release_p = 1'b1;
          phase_d   = StHeld;
        end
      end
      StHeld: begin
        if (!pressed) phase_d = StOn;
      end
      StOn: begin
        if (cfg_i.always_off_mode) begin
          if (!pressed) phase_d = StShutdown;
        end else begin
          press_d  = pressed ? press_inc : '0;
          bright_d = pressed ? BrightHalf : BrightFull;
          if (press_d > cfg_i.press_off_ticks) phase_d = StShutdown;
        end
      end
      StShutdown: begin
        bright_d = BrightOff;
        if (!waiting_q) begin
          if (!pressed) begin
            bus       = 1'b1;
            lock      = 1'b1;
            hold_d    = 1'b0;
            timer_d   = '0;
            waiting_d = 1'b1;
          end
        end else begin
          timer_d = timer_inc;
          if (timer_inc >= off_limit) begin
            hold_d    = 1'b1;
            waiting_d = 1'b0;
            timer_d   = '0;
            phase_d   = StDelay;
          end
        end
      end
      default: phase_d = StDelay;
    endcase
  end

  // Result word built from the updated state.
  always_comb begin
    res_d.power_hold          = hold_d;
    res_d.brightness_level    = bright_d;
    res_d.motor_lock_pulse    = lock;
    res_d.motor_release_pulse = release_p;
    res_d.bus_shutdown_pulse  = bus;
    res_d.phase               = phase_code(phase_d);
  end

  // State updates only when a tick is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= StBooted;
      press_q   <= '0;
      timer_q   <= '0;
      waiting_q <= 1'b0;
      bright_q  <= BrightThree;
      hold_q    <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      press_q   <= press_d;
      timer_q   <= timer_d;
      waiting_q <= waiting_d;
      bright_q  <= bright_d;
      hold_q    <= hold_d;
    end
  end

  // Result register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (step_i) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule
`default_nettype wire
